// ===== hdl/joint_pd_torque_controller_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Joint PD torque controller: assertion macros
// Concurrent check helpers shared by the controller RTL; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef JOINT_PD_TORQUE_CONTROLLER_UNIT_DEFINES_SVH
`define JOINT_PD_TORQUE_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define JPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jpd check failed");
// next-cycle implication, sampled on clk, off during reset
`define JPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jpd check failed");
`else
`define JPD_ASSERT_NOW(lbl, ante, cons)
`define JPD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/jpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Joint PD torque controller package
// Shared types, codes, register indexes and the fixed per-joint gain tables.
// ----------------------------------------------------------------------------
`default_nettype none

package jpd_pkg;

  localparam int MAX_JOINTS_DEF = 64;
  localparam int GAIN_ENTRIES   = 44;
  localparam int JOINT_W        = 6;
  localparam int ANGLE_W        = 32;
  localparam int TORQUE_W       = 48;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int JCOUNT_W       = 7;

  localparam logic [31:0]       INV_TIMESTEP_RST = 32'd13107200;
  localparam logic [JCOUNT_W-1:0] JOINT_COUNT_RST = 7'd44;

  // command carried in the input tuser
  typedef enum logic {
    CMD_PRIME   = 1'b0,
    CMD_CONTROL = 1'b1
  } cmd_t;

  // result status carried in the output tuser
  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_SAT = 2'd1,
    STAT_BAD = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TIMESTEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JOINT_COUNT  = 2'd1;

  // one history entry: the last angles seen for a joint
  typedef struct packed {
    logic [ANGLE_W-1:0] meas_ang;
    logic [ANGLE_W-1:0] ref_ang;
  } hist_t;

  // memory port group between the controller and its history store
  typedef struct packed {
    logic               wr_en;
    logic [7:0]         wr_addr;
    hist_t              wr_data;
    logic               rd_en;
    logic [7:0]         rd_addr;
  } hist_req_t;

  localparam logic [31:0] KP_ROM [0:GAIN_ENTRIES-1] = '{
    32'd500, 32'd300, 32'd300, 32'd300, 32'd300, 32'd800, 32'd800, 32'd100,
    32'd30,  32'd300, 32'd300, 32'd800, 32'd30,  32'd300, 32'd100, 32'd30,
    32'd30,  32'd300, 32'd300, 32'd100, 32'd30,  32'd300, 32'd30,  32'd30,
    32'd30,  32'd30,  32'd30,  32'd30,  32'd30,  32'd30,  32'd30,  32'd30,
    32'd100, 32'd30,  32'd30,  32'd300, 32'd30,  32'd30,  32'd30,  32'd30,
    32'd30,  32'd30,  32'd30,  32'd30
  };

  // derivative gains: every used joint holds 1, the rest 0
  localparam logic [31:0] KD_ROM [0:GAIN_ENTRIES-1] = '{
    32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
    32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
    32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
    32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
    32'd1, 32'd1, 32'd1, 32'd1
  };

  function automatic logic [31:0] kp_gain(input logic [JOINT_W-1:0] j);
    logic [31:0] g;
    g = '0;
    if (int'(j) < GAIN_ENTRIES) begin
      g = KP_ROM[j];
    end
    return g;
  endfunction

  function automatic logic [31:0] kd_gain(input logic [JOINT_W-1:0] j);
    logic [31:0] g;
    g = '0;
    if (int'(j) < GAIN_ENTRIES) begin
      g = KD_ROM[j];
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/jpd_hist_ram.sv =====
// ----------------------------------------------------------------------------
// Joint history RAM
// One-write one-read synchronous store of the previous angles per joint;
// read data is registered, a same-address read returns the old entry.
// ----------------------------------------------------------------------------
`default_nettype none

module jpd_hist_ram #(
  parameter int DEPTH = jpd_pkg::MAX_JOINTS_DEF,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire jpd_pkg::hist_req_t req,
  output jpd_pkg::hist_t         rd_data
);

  jpd_pkg::hist_t mem [0:DEPTH-1];
  jpd_pkg::hist_t rd_data_r;

  // write the new entry, read the old one at the same edge
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/joint_pd_torque_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Joint PD torque controller
// Per-joint PD law with angle history in RAM and fixed per-joint gains.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per joint sample. tuser = command (0 prime, 1 control),
//           tdata = joint, measured angle, reference angle (Q16.16).
//   out_* : one word per accepted input. tdata = joint, torque (Q32.16),
//           tuser = status (0 ok, 1 saturated, 2 bad joint).
//   cfg_* : register writes (0 inv_timestep, 1 joint_count), always ready;
//           write only while no sample is in flight.
// An accepted word moves through the stage 1 to 4 registers to out_tvalid.
// Throughput is one word per cycle while the receiver does not stall, for
// any joint order: the history RAM is written at the
// accept edge and read at the same edge, so the next sample of the same joint
// already sees it. The pipeline is the RAM read, the angle differences, the
// gain multipliers and the sum/saturate output register.
// Reset empties the pipeline and loads inv_timestep 200.0 and joint_count 44;
// the history RAM is not cleared, a joint must be primed before control.
// When the receiver stalls, bubbles close up; in_tready falls only once all
// four stages hold words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "joint_pd_torque_controller_unit_defines.svh"

module joint_pd_torque_controller_unit #(
  parameter int MAX_JOINTS = jpd_pkg::MAX_JOINTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  // [5:0] joint, [37:6] measured_angle, [69:38] reference_angle, [71:70] zero
  input  wire logic [71:0]                     in_tdata,
  // [0] cmd
  input  wire logic                            in_tuser,
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  // [5:0] joint_out, [53:6] torque, [55:54] zero
  output      logic [55:0]                     out_tdata,
  // [1:0] status
  output      logic [1:0]                      out_tuser,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [jpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [jpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int JW = jpd_pkg::JOINT_W;
  localparam int TW = jpd_pkg::TORQUE_W;

  // torque range limits
  localparam logic [TW-1:0] TQ_MAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic [TW-1:0] TQ_MIN = {1'b1, {(TW-1){1'b0}}};

  // config registers
  logic [31:0]                   inv_dt_r;
  logic [jpd_pkg::JCOUNT_W-1:0]  jcount_r;

  // stage 1: accepted word plus RAM read
  logic          v1_r;
  logic          bad1_r, ctl1_r;
  logic [JW-1:0] joint1_r;
  logic [31:0]   meas1_r, refa1_r;
  jpd_pkg::hist_t prev1;

  // stage 2: differences and gains
  logic                v2_r;
  logic                bad2_r, ctl2_r;
  logic [JW-1:0]       joint2_r;
  logic signed [32:0]  err2_r;
  logic signed [33:0]  dx2_r;
  logic [31:0]         kp2_r;

  // stage 3: products
  logic                v3_r;
  logic                bad3_r, ctl3_r;
  logic [JW-1:0]       joint3_r;
  logic signed [64:0]  pterm3_r;
  logic signed [66:0]  dprod3_r;

  // stage 4: output register
  logic                v4_r;
  logic [JW-1:0]       joint4_r;
  logic [TW-1:0]       torque4_r;
  jpd_pkg::status_t    status4_r;

  logic en1, en2, en3, en4;
  logic in_acc;
  logic [JW-1:0]  in_joint;
  logic [31:0]    in_meas, in_refa;
  logic           in_ok;
  jpd_pkg::hist_req_t hreq;

  // stage enables: a stage loads when empty or when its word moves on
  assign en4       = !v4_r || out_tready;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign in_acc    = in_tvalid && en1;
  assign cfg_ready = 1'b1;

  assign in_joint = in_tdata[5:0];
  assign in_meas  = in_tdata[37:6];
  assign in_refa  = in_tdata[69:38];
  assign in_ok    = (int'(in_joint) < int'(jcount_r)) && (int'(in_joint) < MAX_JOINTS);

  // write history at accept, read the previous entry at the same edge
  always_comb begin
    hreq                  = '0;
    hreq.wr_en            = in_acc && in_ok;
    hreq.wr_addr          = 8'(in_joint);
    hreq.wr_data.meas_ang = in_meas;
    hreq.wr_data.ref_ang  = in_refa;
    hreq.rd_en            = en1;
    hreq.rd_addr          = 8'(in_joint);
  end

  jpd_hist_ram #(
    .DEPTH (MAX_JOINTS),
    .AW    (AW)
  ) u_hist (
    .clk     (clk),
    .req     (hreq),
    .rd_data (prev1)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_dt_r <= jpd_pkg::INV_TIMESTEP_RST;
      jcount_r <= jpd_pkg::JOINT_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == jpd_pkg::CFG_INV_TIMESTEP) begin
        inv_dt_r <= cfg_data;
      end else if (cfg_index == jpd_pkg::CFG_JOINT_COUNT) begin
        jcount_r <= cfg_data[jpd_pkg::JCOUNT_W-1:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: capture the accepted word
  always_ff @(posedge clk) begin
    if (en1) begin
      bad1_r   <= !in_ok;
      ctl1_r   <= (in_tuser == jpd_pkg::CMD_CONTROL);
      joint1_r <= in_joint;
      meas1_r  <= in_meas;
      refa1_r  <= in_refa;
    end
  end

  // stage 2: angle error, derivative difference, gain lookup
  logic signed [32:0] err_c, dref_c, dmeas_c;
  logic signed [33:0] dx_c;
  logic [31:0]        kd_c;
  always_comb begin
    err_c   = $signed({refa1_r[31], refa1_r}) - $signed({meas1_r[31], meas1_r});
    dref_c  = $signed({refa1_r[31], refa1_r}) -
              $signed({prev1.ref_ang[31], prev1.ref_ang});
    dmeas_c = $signed({meas1_r[31], meas1_r}) -
              $signed({prev1.meas_ang[31], prev1.meas_ang});
    dx_c    = $signed({dref_c[32], dref_c}) - $signed({dmeas_c[32], dmeas_c});
    kd_c    = jpd_pkg::kd_gain(joint1_r);
    // derivative gains are only 0 or 1, so the gain reduces to a gate
    if (!kd_c[0]) begin
      dx_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      bad2_r   <= bad1_r;
      ctl2_r   <= ctl1_r;
      joint2_r <= joint1_r;
      err2_r   <= err_c;
      dx2_r    <= dx_c;
      kp2_r    <= jpd_pkg::kp_gain(joint1_r);
    end
  end

  // stage 3: proportional and derivative products, full width
  always_ff @(posedge clk) begin
    if (en3) begin
      bad3_r   <= bad2_r;
      ctl3_r   <= ctl2_r;
      joint3_r <= joint2_r;
      pterm3_r <= 65'(err2_r) * 65'($signed({1'b0, kp2_r}));
      dprod3_r <= 67'(dx2_r) * 67'($signed({1'b0, inv_dt_r}));
    end
  end

  // stage 4: floor to Q.16, sum, saturate
  logic signed [65:0]  sum_c;
  logic [TW-1:0]       torque_c;
  jpd_pkg::status_t    status_c;
  logic                sat_hi, sat_lo;
  always_comb begin
    sum_c    = $signed({pterm3_r[64], pterm3_r}) +
               66'($signed(dprod3_r[66:16]));
    sat_hi   = !sum_c[65] && (sum_c[64:TW-1] != '0);
    sat_lo   = sum_c[65] && (sum_c[64:TW-1] != '1);
    torque_c = '0;
    status_c = jpd_pkg::STAT_OK;
    if (bad3_r) begin
      status_c = jpd_pkg::STAT_BAD;
    end else if (ctl3_r) begin
      if (sat_hi) begin
        torque_c = TQ_MAX;
        status_c = jpd_pkg::STAT_SAT;
      end else if (sat_lo) begin
        torque_c = TQ_MIN;
        status_c = jpd_pkg::STAT_SAT;
      end else begin
        torque_c = sum_c[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      joint4_r  <= joint3_r;
      torque4_r <= torque_c;
      status4_r <= status_c;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {2'b00, torque4_r, joint4_r};
  assign out_tuser  = status4_r;

  // checks
  `JPD_ASSERT_NOW(a_bad_is_zero, v4_r && (status4_r == jpd_pkg::STAT_BAD), torque4_r == '0)
  `JPD_ASSERT_NOW(a_sat_at_limit, v4_r && (status4_r == jpd_pkg::STAT_SAT),
                  (torque4_r == TQ_MAX) || (torque4_r == TQ_MIN))
  `JPD_ASSERT_NOW(a_stall_only_full, !in_tready, v1_r && v2_r && v3_r && v4_r && !out_tready)
  `JPD_ASSERT_NEXT(a_stage_moves, v3_r && en4, out_tvalid)

endmodule

`default_nettype wire

// ===== dv/tb_joint_pd_torque_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Joint PD torque controller testbench
// Streams prime and control samples across the joint range through the controller
// under several gain-rate and joint-count settings, with random gaps on both
// stream sides and one long output stall. A scoreboard recomputes each torque
// word from its own joint history and compares the results in order.
// ----------------------------------------------------------------------------
module tb_joint_pd_torque_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_TAIL   = 16;
  localparam int PHASES       = 9;
  localparam int PHASE_WORDS  = 125;
  localparam int REPORT_CAP   = 40;

  // register slots that hold nothing; writes there must be dropped
  localparam logic [jpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [jpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic signed [127:0] TERM_CAP   = 128'sh1000_0000_0000_0000;
  localparam logic signed [127:0] TORQUE_MAX = 128'sh7FFF_FFFF_FFFF;
  localparam logic signed [127:0] TORQUE_MIN = -TORQUE_MAX - 1;

  typedef struct {
    logic [5:0]        joint;
    logic [47:0]       torque;
    jpd_pkg::status_t  status;
  } torque_word_t;

  // --------------------------------------------------------------------------
  // Torque tracker: joint history, gains, settings and pending torque words
  // --------------------------------------------------------------------------
  class torque_tracker;
    logic [31:0]        inv_step;
    logic [6:0]         joint_count;
    logic signed [31:0] last_meas [64];
    logic signed [31:0] last_ref  [64];
    bit                 written   [64];
    int unsigned        prop_gain [64];
    int unsigned        damp_gain [64];
    torque_word_t       pending_torques [$];
    int                 mismatches;
    int                 checked;
    int                 primes;
    int                 controls;
    int                 saturated;
    int                 bad_joints;
    int                 settings;

    function new();
      int unsigned kp_list [44];
      kp_list = '{500, 300, 300, 300, 300, 800, 800, 100, 30, 300,
                  300, 800, 30, 300, 100, 30, 30, 300, 300, 100,
                  30, 300, 30, 30, 30, 30, 30, 30, 30, 30,
                  30, 30, 100, 30, 30, 300, 30, 30, 30, 30,
                  30, 30, 30, 30};
      // joints past the gain list carry zero gains
      for (int j = 0; j < 64; j++) begin
        prop_gain[j] = (j < 44) ? kp_list[j] : 0;
        damp_gain[j] = (j < 44) ? 1 : 0;
        written[j]   = 1'b0;
        last_meas[j] = '0;
        last_ref[j]  = '0;
      end
      inv_step    = 32'd13107200;  // 200.0 per second in Q16.16
      joint_count = 7'd44;
      mismatches  = 0;
      checked     = 0;
      primes      = 0;
      controls    = 0;
      saturated   = 0;
      bad_joints  = 0;
      settings    = 0;
    endfunction

    function void set_register(logic [jpd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        jpd_pkg::CFG_INV_TIMESTEP: begin
          inv_step = data;
          settings++;
        end
        jpd_pkg::CFG_JOINT_COUNT: begin
          joint_count = data[6:0];
        end
        default: begin
        end
      endcase
    endfunction

    // limit a term magnitude to TERM_CAP before summing
    function logic signed [127:0] clamp_term(logic signed [127:0] v);
      logic signed [127:0] r;
      r = v;
      if (v > TERM_CAP) begin
        r = TERM_CAP;
      end else if (v < -TERM_CAP) begin
        r = -TERM_CAP;
      end
      return r;
    endfunction

    // predict the torque word for one accepted sample and advance history
    function void note_sample(jpd_pkg::cmd_t cmd, logic [5:0] joint,
                              logic signed [31:0] meas, logic signed [31:0] ref_ang);
      torque_word_t        want;
      logic signed [127:0] err;
      logic signed [127:0] swing;
      logic signed [127:0] kp_w;
      logic signed [127:0] kd_w;
      logic signed [127:0] inv_w;
      logic signed [127:0] p_part;
      logic signed [127:0] d_part;
      logic signed [127:0] total;
      want.joint  = joint;
      want.torque = '0;
      want.status = jpd_pkg::STAT_OK;
      if (joint >= joint_count) begin
        want.status = jpd_pkg::STAT_BAD;
        bad_joints++;
      end else begin
        if (cmd == jpd_pkg::CMD_CONTROL) begin
          kp_w   = prop_gain[joint];
          kd_w   = damp_gain[joint];
          inv_w  = inv_step;
          err    = ref_ang - meas;
          swing  = (ref_ang - last_ref[joint]) - (meas - last_meas[joint]);
          p_part = clamp_term(err * kp_w);
          // arithmetic shift rounds toward minus infinity
          d_part = clamp_term((swing * kd_w * inv_w) >>> 16);
          total  = p_part + d_part;
          if (total > TORQUE_MAX) begin
            total       = TORQUE_MAX;
            want.status = jpd_pkg::STAT_SAT;
          end else if (total < TORQUE_MIN) begin
            total       = TORQUE_MIN;
            want.status = jpd_pkg::STAT_SAT;
          end
          if (want.status == jpd_pkg::STAT_SAT) begin
            saturated++;
          end
          want.torque = total[47:0];
          controls++;
        end else begin
          primes++;
        end
        last_meas[joint] = meas;
        last_ref[joint]  = ref_ang;
        written[joint]   = 1'b1;
      end
      pending_torques.push_back(want);
    endfunction

    function int pending();
      return pending_torques.size();
    endfunction

    task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < REPORT_CAP) begin
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      end
      mismatches++;
    endtask

    // compare one result word with the oldest prediction
    task check_torque(logic [5:0] joint, logic [47:0] torque, logic [1:0] status);
      torque_word_t want;
      if (pending_torques.size() == 0) begin
        flag_mismatch("unexpected result word", {58'd0, joint}, 64'd0);
      end else begin
        want = pending_torques.pop_front();
        checked++;
        if (joint !== want.joint) begin
          flag_mismatch("joint_out", {58'd0, joint}, {58'd0, want.joint});
        end
        if (torque !== want.torque) begin
          flag_mismatch("torque", {16'd0, torque}, {16'd0, want.torque});
        end
        if (status !== want.status) begin
          flag_mismatch("status", {62'd0, status}, {62'd0, want.status});
        end
      end
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [71:0]                     in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [55:0]                     out_tdata;
  logic [1:0]                      out_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [jpd_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [jpd_pkg::CFG_DATA_W-1:0]  cfg_data;

  torque_tracker sb;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  bit            hold_request;
  int            holds_done;
  int            cycle_count;

  joint_pd_torque_controller_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // abort a hung run
  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding",
               cycle_count, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // check every result word at its accept edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_torque(out_tdata[5:0], out_tdata[53:6], out_tuser);
    end
  end

  // drive out_tready: random back-pressure plus one long stall on request
  initial begin
    int hold_left;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready   = 1'b0;
        hold_left    = LONG_HOLD;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
        holds_done++;
      end
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // send one sample word, note it at its accept edge
  task automatic send_item(jpd_pkg::cmd_t cmd, logic [5:0] joint,
                           logic [31:0] meas, logic [31:0] ref_ang);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {2'b00, ref_ang, meas, joint};
    do begin
      @(posedge clk);
    end while (!in_tready);
    sb.note_sample(cmd, joint, meas, ref_ang);
    @(negedge clk);
  endtask

  task automatic write_register(logic [jpd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drop the input and wait until every predicted word has come back
  task automatic settle_pipeline();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
  endtask

  // next angle: a small step, a fresh value, a range corner or a repeat
  function automatic logic [31:0] pick_angle(logic [31:0] last);
    int unsigned roll;
    logic [31:0] a;
    roll = $urandom_range(99);
    if (roll < 40) begin
      a = last + $urandom_range(8192) - 32'd4096;
    end else if (roll < 75) begin
      a = $urandom();
    end else if (roll < 90) begin
      case ($urandom_range(4))
        0:       a = 32'h8000_0000;
        1:       a = 32'h7FFF_FFFF;
        2:       a = 32'h0000_0000;
        3:       a = 32'hFFFF_FFFF;
        default: a = 32'h0000_0001;
      endcase
    end else begin
      a = last;
    end
    return a;
  endfunction

  // random samples: prime any unwritten joint first, mostly control after
  task automatic run_random(int words, bit with_stall);
    logic [5:0]    joint;
    jpd_pkg::cmd_t cmd;
    logic [31:0]   meas;
    logic [31:0]   ref_ang;
    for (int k = 0; k < words; k++) begin
      if ($urandom_range(99) < 85) begin
        joint = $urandom_range(sb.joint_count - 1);
      end else begin
        joint = $urandom_range(63);
      end
      if (joint < sb.joint_count && !sb.written[joint]) begin
        cmd = jpd_pkg::CMD_PRIME;
      end else begin
        cmd = ($urandom_range(99) < 20) ? jpd_pkg::CMD_PRIME : jpd_pkg::CMD_CONTROL;
      end
      meas    = pick_angle(sb.last_meas[joint]);
      ref_ang = pick_angle(sb.last_ref[joint]);
      if (with_stall && k == words / 2) begin
        hold_request = 1'b1;
      end
      send_item(cmd, joint, meas, ref_ang);
    end
  endtask

  initial begin
    logic [31:0] step;
    logic [31:0] count;
    sb            = new();
    send_idle_pct = 21;
    recv_idle_pct = 51;
    hold_request  = 1'b0;
    holds_done    = 0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: extreme errors, history reuse, out-of-range joints
    send_item(jpd_pkg::CMD_PRIME,   6'd0,  32'h0000_0000, 32'h0000_0000);
    send_item(jpd_pkg::CMD_CONTROL, 6'd0,  32'h0000_0000, 32'h7FFF_FFFF);
    send_item(jpd_pkg::CMD_CONTROL, 6'd0,  32'h7FFF_FFFF, 32'h8000_0000);
    send_item(jpd_pkg::CMD_CONTROL, 6'd0,  32'h8000_0000, 32'h7FFF_FFFF);
    send_item(jpd_pkg::CMD_PRIME,   6'd5,  32'h8000_0000, 32'h8000_0000);
    send_item(jpd_pkg::CMD_CONTROL, 6'd5,  32'h7FFF_FFFF, 32'h8000_0000);
    send_item(jpd_pkg::CMD_PRIME,   6'd43, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(jpd_pkg::CMD_CONTROL, 6'd43, 32'h0000_0001, 32'hFFFF_FFFF);
    send_item(jpd_pkg::CMD_CONTROL, 6'd44, 32'h1234_5678, 32'h0000_0000);
    send_item(jpd_pkg::CMD_PRIME,   6'd63, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(jpd_pkg::CMD_CONTROL, 6'd5,  32'h7FFF_FFFF, 32'h8000_0000);
    send_item(jpd_pkg::CMD_PRIME,   6'd7,  32'h0001_0000, 32'hFFFF_0000);
    send_item(jpd_pkg::CMD_CONTROL, 6'd7,  32'hFFFF_0000, 32'h0001_0000);
    settle_pipeline();

    // top rate and all joints: saturate both ways, zero-gain joints
    write_register(jpd_pkg::CFG_INV_TIMESTEP, 32'hFFFF_FFFF);
    write_register(jpd_pkg::CFG_JOINT_COUNT, 32'd64);
    write_register(CFG_SPARE_LO, $urandom());
    write_register(CFG_SPARE_HI, $urandom());
    send_item(jpd_pkg::CMD_CONTROL, 6'd0,  32'h7FFF_FFFF, 32'h8000_0000);
    send_item(jpd_pkg::CMD_CONTROL, 6'd0,  32'h8000_0000, 32'h7FFF_FFFF);
    send_item(jpd_pkg::CMD_PRIME,   6'd63, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(jpd_pkg::CMD_CONTROL, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(jpd_pkg::CMD_PRIME,   6'd44, $urandom(), $urandom());
    send_item(jpd_pkg::CMD_CONTROL, 6'd44, $urandom(), $urandom());

    // random phases; idle pattern changes every three phases
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_pipeline();
      case (ph / 3)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph)
        0: begin
          step  = 32'd13107200;
          count = 32'd44;
        end
        1: begin
          step  = 32'hFFFF_FFFF;
          count = 32'd64;
        end
        2: begin
          step  = 32'd1;
          count = 32'd1;
        end
        3: begin
          step  = $urandom();
          count = $urandom_range(64, 1);
        end
        4: begin
          step  = 32'd0;
          count = 32'd64;
        end
        5: begin
          step  = 32'h0001_0000;
          count = 32'd20;
        end
        6: begin
          step  = 32'hFFFF_FFFF;
          count = 32'd64;
        end
        7: begin
          step  = $urandom_range(32'h0100_0000);
          count = $urandom_range(64, 1);
        end
        default: begin
          step  = 32'd13107200;
          count = 32'd44;
        end
      endcase
      write_register(jpd_pkg::CFG_INV_TIMESTEP, step);
      write_register(jpd_pkg::CFG_JOINT_COUNT, count);
      run_random(PHASE_WORDS, ph == 7);
    end

    settle_pipeline();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (sb.pending() != 0) begin
      sb.flag_mismatch("words never returned", sb.pending(), 64'd0);
    end
    $display("Checked %0d torque words: %0d prime, %0d control (%0d saturated), %0d bad joint",
             sb.checked, sb.primes, sb.controls, sb.saturated, sb.bad_joints);
    $display("Used %0d rate settings, three idle patterns, %0d long output stall(s); %0d mismatches",
             sb.settings, holds_done, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
